// ===== rtl/core/i2cs_pkg.sv =====
package i2cs_pkg;

    // Default depth of the receive buffer and of the register file
    localparam int unsigned BUF_SIZE_DEF = 16;

    // Width of the wide copy arithmetic (pointer byte plus index)
    localparam int unsigned DST_W = 9;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'b1;

    // Reset values of the configuration registers
    localparam logic [6:0]  OWN_ADDRESS_RST   = 7'd80;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd500;

    // Event kinds of an input item
    localparam logic [1:0] ACT_SCL  = 2'd0;
    localparam logic [1:0] ACT_SDA  = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    // Bus phase as reported on bus_state
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_DATA  = 3'd2,
        PH_ACK   = 3'd3,
        PH_NACK  = 3'd4
    } phase_t;

    // Receive buffer read address select
    typedef enum logic [1:0] {
        RD_HDR  = 2'd0,
        RD_ZERO = 2'd1,
        RD_COPY = 2'd2
    } rd_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    capture;
        rd_sel_t rd_sel;
        logic    exec;
        logic    emit;
        logic    copy_write;
        logic    clr_write;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic stop_commit;
        logic hdr_match;
        logic copy_break;
        logic copy_last;
        logic clr_last;
    } dp_status_t;

endpackage

// ===== rtl/core/i2c_slave_register_file.sv =====
// I2C slave with a register file and a register pointer, fed one line event
// per item (SCL edge, SDA edge or time tick) and giving one result item per
// event. An ordinary event is captured, then reads the receive buffer and
// register file, then executes and gives its result once the output is free. A STOP
// that ends a write of three or more bytes walks the buffer through the
// single memory port: a header check, then a read and a write for each byte
// copied into the register file and a write for each buffer entry cleared.
// A new item is taken while an earlier result still waits on the output.
// Configuration writes (index 0 own address, index 1 timeout in ticks) are
// always taken. After reset the buffer and the register file read as zero.
module i2c_slave_register_file
    import i2cs_pkg::*;
#(
    parameter int unsigned BUF_SIZE = BUF_SIZE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           action,
    input  logic                 scl_level,
    input  logic                 sda_level,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 sda_drive_enable,
    output logic                 sda_drive_level,
    output logic [2:0]           bus_state,
    output logic [3:0]           committed_bytes,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    i2cs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    i2cs_datapath #(
        .BUF_SIZE (BUF_SIZE)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .action           (action),
        .scl_level        (scl_level),
        .sda_level        (sda_level),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .sda_drive_enable (sda_drive_enable),
        .sda_drive_level  (sda_drive_level),
        .bus_state        (bus_state),
        .committed_bytes  (committed_bytes)
    );

endmodule

// ===== rtl/core/i2cs_ctrl.sv =====
module i2cs_ctrl
    import i2cs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_EXEC  = 8'b0000_0100,
        S_CHECK = 8'b0000_1000,
        S_CRD   = 8'b0001_0000,
        S_CWR   = 8'b0010_0000,
        S_CLR   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Sequencer: read, execute, optional STOP commit walk, result
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = RD_HDR;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd_sel = RD_HDR;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (status.stop_commit)
                begin
                    cmd.exec   = 1'b1;
                    cmd.rd_sel = RD_ZERO;
                    state_next = S_CHECK;
                end
                else if (out_free)
                begin
                    cmd.exec   = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CHECK:
            begin
                if (status.hdr_match)
                    state_next = S_CRD;
                else
                    state_next = S_DONE;
            end
            S_CRD:
            begin
                cmd.rd_sel = RD_COPY;
                state_next = S_CWR;
            end
            S_CWR:
            begin
                if (status.copy_break)
                    state_next = S_CLR;
                else
                begin
                    cmd.copy_write = 1'b1;
                    if (status.copy_last)
                        state_next = S_CLR;
                    else
                        state_next = S_CRD;
                end
            end
            S_CLR:
            begin
                cmd.clr_write = 1'b1;
                if (status.clr_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/i2cs_datapath.sv =====
module i2cs_datapath
    import i2cs_pkg::*;
#(
    parameter int unsigned BUF_SIZE = BUF_SIZE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  logic [1:0]           action,
    input  logic                 scl_level,
    input  logic                 sda_level,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output logic                 sda_drive_enable,
    output logic                 sda_drive_level,
    output logic [2:0]           bus_state,
    output logic [3:0]           committed_bytes
);

    localparam int unsigned IW = $clog2(BUF_SIZE);

    // Captured item
    logic [1:0] action_reg;
    logic       scl_reg;
    logic       sda_reg;

    // Configuration
    logic [6:0]  own_address_reg;
    logic [15:0] timeout_ticks_reg;

    // Bus state
    phase_t        phase_reg, phase_next;
    logic          master_reads_reg, master_reads_next;
    logic [3:0]    fec_reg, fec_next;
    logic          matched_reg, matched_next;
    logic [IW-1:0] rx_idx_reg, rx_idx_next;
    logic [IW-1:0] tx_idx_reg, tx_idx_next;
    logic [7:0]    cur_reg, cur_next;
    logic [15:0]   idle_ticks_reg, idle_ticks_next;
    logic          de_reg, de_next;
    logic          dl_reg, dl_next;

    // Commit walk
    logic [7:0]    ptr_reg, ptr_next;
    logic [IW-1:0] copy_idx_reg, copy_idx_next;
    logic [IW-1:0] clr_idx_reg, clr_idx_next;
    logic [IW-1:0] n_reg, n_next;

    // Result
    logic       out_de_reg;
    logic       out_dl_reg;
    logic [2:0] out_phase_reg;
    logic [3:0] out_committed_reg;

    // Receive buffer memory
    logic [7:0]          rx_mem [BUF_SIZE];
    logic [BUF_SIZE-1:0] rx_vld_reg;
    logic                rx_we;
    logic [IW-1:0]       rx_waddr;
    logic [7:0]          rx_wdata;
    logic [IW-1:0]       rx_raddr;
    logic [7:0]          rx_rd_reg;
    logic                rx_rd_vld_reg;
    logic [7:0]          rx_rd_byte;

    // Register file memory
    logic [7:0]          rf_mem [BUF_SIZE];
    logic [BUF_SIZE-1:0] rf_vld_reg;
    logic                rf_we;
    logic [IW-1:0]       rf_waddr;
    logic [7:0]          rf_rd_reg;
    logic                rf_rd_vld_reg;
    logic [7:0]          tx_byte;

    // Helpers
    logic [3:0]       fec_inc;
    logic [15:0]      ticks_inc;
    logic [DST_W-1:0] dst;
    logic [DST_W-1:0] n_ext;

    function automatic logic [IW-1:0] bump_index(input logic [IW-1:0] v);
        logic [IW:0] inc;
        inc = {1'b0, v} + {{IW{1'b0}}, 1'b1};
        if (inc >= (IW+1)'(BUF_SIZE - 1))
            bump_index = '0;
        else
            bump_index = inc[IW-1:0];
    endfunction

    // Entries never written read as zero
    assign rx_rd_byte = rx_rd_vld_reg ? rx_rd_reg : 8'h00;
    assign tx_byte    = rf_rd_vld_reg ? rf_rd_reg : 8'h00;

    // Status toward the controller
    assign dst = DST_W'(ptr_reg) + DST_W'(copy_idx_reg) - DST_W'(2);

    always_comb
    begin
        status.stop_commit = (action_reg == ACT_SDA) && scl_reg && sda_reg &&
                             ((IW+1)'(rx_idx_reg) >= (IW+1)'(3));
        status.hdr_match   = (rx_rd_byte == {own_address_reg, 1'b0});
        status.copy_break  = (dst > DST_W'(BUF_SIZE - 1));
        status.copy_last   = ({1'b0, copy_idx_reg} + (IW+1)'(1)) == {1'b0, rx_idx_reg};
        status.clr_last    = ({1'b0, clr_idx_reg} + (IW+1)'(1)) == {1'b0, rx_idx_reg};
    end

    // Receive buffer read address
    always_comb
    begin
        case (cmd.rd_sel)
            RD_HDR:  rx_raddr = IW'(1);
            RD_ZERO: rx_raddr = '0;
            RD_COPY: rx_raddr = copy_idx_reg;
            default: rx_raddr = '0;
        endcase
    end

    // Item execution and commit walk
    always_comb
    begin
        phase_next        = phase_reg;
        master_reads_next = master_reads_reg;
        fec_next          = fec_reg;
        matched_next      = matched_reg;
        rx_idx_next       = rx_idx_reg;
        tx_idx_next       = tx_idx_reg;
        cur_next          = cur_reg;
        idle_ticks_next   = idle_ticks_reg;
        de_next           = de_reg;
        dl_next           = dl_reg;
        ptr_next          = ptr_reg;
        copy_idx_next     = copy_idx_reg;
        clr_idx_next      = clr_idx_reg;
        n_next            = n_reg;
        rx_we             = 1'b0;
        rx_waddr          = rx_idx_reg;
        rx_wdata          = 8'h00;
        rf_we             = 1'b0;
        rf_waddr          = dst[IW-1:0];
        fec_inc           = fec_reg + 4'd1;
        ticks_inc         = (idle_ticks_reg == 16'hFFFF) ? idle_ticks_reg
                                                         : idle_ticks_reg + 16'd1;

        if (cmd.exec)
        begin
            n_next        = '0;
            copy_idx_next = IW'(2);
            clr_idx_next  = '0;
            case (action_reg)
                ACT_SCL:
                begin
                    idle_ticks_next = '0;
                    if (!scl_reg)
                    begin
                        // SCL falling edge
                        case (phase_reg)
                            PH_START:
                            begin
                                fec_next = '0;
                                if (DST_W'(rx_rd_byte) >= DST_W'(BUF_SIZE))
                                    tx_idx_next = '0;
                                else
                                    tx_idx_next = rx_rd_byte[IW-1:0];
                                rx_idx_next       = '0;
                                matched_next      = 1'b0;
                                cur_next          = 8'h00;
                                rx_we             = 1'b1;
                                rx_waddr          = '0;
                                rx_wdata          = 8'h00;
                                master_reads_next = 1'b0;
                                phase_next        = PH_DATA;
                            end
                            PH_DATA:
                            begin
                                fec_next = fec_inc;
                                if (fec_inc < 4'd8)
                                begin
                                    if (master_reads_reg)
                                        dl_next = tx_byte[3'd7 - fec_inc[2:0]];
                                end
                                else if (fec_inc == 4'd8)
                                begin
                                    if (!master_reads_reg)
                                    begin
                                        // address byte check
                                        if (rx_idx_reg == '0 &&
                                            cur_reg[7:1] == own_address_reg)
                                        begin
                                            matched_next      = 1'b1;
                                            master_reads_next = cur_reg[0];
                                        end
                                        if (matched_next)
                                        begin
                                            de_next = 1'b1;
                                            dl_next = 1'b0;
                                        end
                                    end
                                    else
                                    begin
                                        de_next     = 1'b0;
                                        tx_idx_next = bump_index(tx_idx_reg);
                                    end
                                    phase_next = PH_ACK;
                                end
                            end
                            PH_ACK:
                            begin
                                fec_next = '0;
                                if (!master_reads_reg)
                                begin
                                    de_next     = 1'b0;
                                    rx_idx_next = bump_index(rx_idx_reg);
                                    cur_next    = 8'h00;
                                    rx_we       = 1'b1;
                                    rx_waddr    = rx_idx_next;
                                    rx_wdata    = 8'h00;
                                end
                                else
                                begin
                                    de_next = 1'b1;
                                    dl_next = tx_byte[7];
                                end
                                phase_next = PH_DATA;
                            end
                            PH_NACK:
                            begin
                                fec_next = '0;
                                de_next  = 1'b0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    else
                    begin
                        // SCL rising edge: sample data or master ACK
                        if (phase_reg == PH_DATA)
                        begin
                            if (!master_reads_reg && fec_reg < 4'd8 && sda_reg)
                            begin
                                cur_next = cur_reg | (8'h80 >> fec_reg[2:0]);
                                rx_we    = 1'b1;
                                rx_waddr = rx_idx_reg;
                                rx_wdata = cur_next;
                            end
                        end
                        else if (phase_reg == PH_ACK)
                        begin
                            if (master_reads_reg && sda_reg)
                                phase_next = PH_NACK;
                        end
                    end
                end
                ACT_SDA:
                begin
                    if (scl_reg)
                    begin
                        if (!sda_reg)
                            phase_next = PH_START;
                        else
                        begin
                            // STOP; pointer byte is on the read port
                            phase_next = PH_IDLE;
                            ptr_next   = rx_rd_byte;
                        end
                    end
                end
                ACT_TICK:
                begin
                    idle_ticks_next = ticks_inc;
                    if (phase_reg != PH_IDLE && ticks_inc > timeout_ticks_reg)
                    begin
                        phase_next = PH_IDLE;
                        de_next    = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Copy one received byte into the register file
        if (cmd.copy_write)
        begin
            rf_we         = 1'b1;
            n_next        = n_reg + IW'(1);
            copy_idx_next = copy_idx_reg + IW'(1);
        end

        // Clear one used buffer entry
        if (cmd.clr_write)
        begin
            rx_we        = 1'b1;
            rx_waddr     = clr_idx_reg;
            rx_wdata     = 8'h00;
            clr_idx_next = clr_idx_reg + IW'(1);
            if (status.clr_last)
            begin
                rx_idx_next = '0;
                cur_next    = 8'h00;
            end
        end
    end

    assign n_ext = DST_W'(n_next);

    // Control and bus state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg   <= OWN_ADDRESS_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
            phase_reg         <= PH_IDLE;
            master_reads_reg  <= 1'b0;
            fec_reg           <= '0;
            matched_reg       <= 1'b0;
            rx_idx_reg        <= '0;
            tx_idx_reg        <= '0;
            cur_reg           <= '0;
            idle_ticks_reg    <= '0;
            de_reg            <= 1'b0;
            dl_reg            <= 1'b1;
            copy_idx_reg      <= '0;
            clr_idx_reg       <= '0;
            n_reg             <= '0;
            rx_vld_reg        <= '0;
            rf_vld_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_OWN_ADDRESS:   own_address_reg   <= cfg_data[6:0];
                    CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            phase_reg        <= phase_next;
            master_reads_reg <= master_reads_next;
            fec_reg          <= fec_next;
            matched_reg      <= matched_next;
            rx_idx_reg       <= rx_idx_next;
            tx_idx_reg       <= tx_idx_next;
            cur_reg          <= cur_next;
            idle_ticks_reg   <= idle_ticks_next;
            de_reg           <= de_next;
            dl_reg           <= dl_next;
            copy_idx_reg     <= copy_idx_next;
            clr_idx_reg      <= clr_idx_next;
            n_reg            <= n_next;
            if (rx_we)
                rx_vld_reg[rx_waddr] <= 1'b1;
            if (rf_we)
                rf_vld_reg[rf_waddr] <= 1'b1;
        end
    end

    // Payload registers: captured item, pointer, result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            scl_reg    <= scl_level;
            sda_reg    <= sda_level;
        end
        ptr_reg <= ptr_next;
        if (cmd.emit)
        begin
            out_de_reg        <= de_next;
            out_dl_reg        <= dl_next;
            out_phase_reg     <= phase_next;
            out_committed_reg <= (n_ext > DST_W'(15)) ? 4'd15 : n_ext[3:0];
        end
    end

    // Receive buffer
    always_ff @(posedge clk)
    begin
        if (rx_we)
            rx_mem[rx_waddr] <= rx_wdata;
        rx_rd_reg     <= rx_mem[rx_raddr];
        rx_rd_vld_reg <= rx_vld_reg[rx_raddr];
    end

    // Register file
    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf_mem[rf_waddr] <= rx_rd_byte;
        rf_rd_reg     <= rf_mem[tx_idx_reg];
        rf_rd_vld_reg <= rf_vld_reg[tx_idx_reg];
    end

    assign sda_drive_enable = out_de_reg;
    assign sda_drive_level  = out_dl_reg;
    assign bus_state        = out_phase_reg;
    assign committed_bytes  = out_committed_reg;

endmodule
